[rtl/core/pid_position_incremental_core_macros.svh]
// Assertion helpers for the checker file of the PID core.
`ifndef PID_POSITION_INCREMENTAL_CORE_MACROS_SVH
`define PID_POSITION_INCREMENTAL_CORE_MACROS_SVH

// Clocked check, switched off while reset is low.
`define PIDPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PIDPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pidpi_pkg.sv]
`timescale 1ns / 1ps

package pidpi_pkg;

    // Sample width and fixed-point position.
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // Fixed register and state widths.
    localparam int GAIN_W      = 16;
    localparam int SUM_W       = 32;
    localparam int INT_BOUND_W = SUM_W - 1;
    localparam int OUT_BOUND_W = 15;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 3;

    // Derived datapath widths.
    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 2;
    localparam int OPI_W  = (SUM_W > ERR_W) ? SUM_W : ERR_W;
    localparam int OPW_W  = (OPI_W > D2_W) ? OPI_W : D2_W;
    localparam int ACC_W  = GAIN_W + OPW_W + 2;

    // Stream payload widths, whole bytes.
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Saturation limits of the drive, at accumulator width.
    localparam logic signed [ACC_W-1:0] DRV_MAX =
        {{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DRV_MIN = ~DRV_MAX;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_INT_CLAMP_ON,
        REG_INT_BOUND,
        REG_OUT_CLAMP_ON,
        REG_OUT_BOUND
    } t_reg_idx;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic                     int_clamp_on;
        logic [INT_BOUND_W-1:0]   int_bound;
        logic                     out_clamp_on;
        logic [OUT_BOUND_W-1:0]   out_bound;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0]      error_sum;
        logic signed [ERR_W-1:0]      prev_error;
        logic signed [ERR_W-1:0]      prev_prev_error;
        logic signed [DATA_WIDTH-1:0] prev_drive;
    } t_state;

endpackage

[rtl/core/pidpi_cfg.sv]
`timescale 1ns / 1ps

module pidpi_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidpi_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [pidpi_pkg::CFG_W-1:0]      i_cfg_wdata,
    output pidpi_pkg::t_cfg                  o_cfg
);

    pidpi_pkg::t_cfg r_cfg;

    // Write one register per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= pidpi_pkg::MODE_POSITIONAL;
            r_cfg.gain_p       <= '0;
            r_cfg.gain_i       <= '0;
            r_cfg.gain_d       <= '0;
            r_cfg.int_clamp_on <= 1'b0;
            r_cfg.int_bound    <= '0;
            r_cfg.out_clamp_on <= 1'b0;
            r_cfg.out_bound    <= '1;
        end else if (i_cfg_we) begin
            case (pidpi_pkg::t_reg_idx'(i_cfg_addr))
                pidpi_pkg::REG_MODE:         r_cfg.mode <= i_cfg_wdata[0];
                pidpi_pkg::REG_GAIN_P:
                    r_cfg.gain_p <= $signed(i_cfg_wdata[pidpi_pkg::GAIN_W-1:0]);
                pidpi_pkg::REG_GAIN_I:
                    r_cfg.gain_i <= $signed(i_cfg_wdata[pidpi_pkg::GAIN_W-1:0]);
                pidpi_pkg::REG_GAIN_D:
                    r_cfg.gain_d <= $signed(i_cfg_wdata[pidpi_pkg::GAIN_W-1:0]);
                pidpi_pkg::REG_INT_CLAMP_ON: r_cfg.int_clamp_on <= i_cfg_wdata[0];
                pidpi_pkg::REG_INT_BOUND:
                    r_cfg.int_bound <= i_cfg_wdata[pidpi_pkg::INT_BOUND_W-1:0];
                pidpi_pkg::REG_OUT_CLAMP_ON: r_cfg.out_clamp_on <= i_cfg_wdata[0];
                pidpi_pkg::REG_OUT_BOUND:
                    r_cfg.out_bound <= i_cfg_wdata[pidpi_pkg::OUT_BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pidpi_calc.sv]
`timescale 1ns / 1ps

module pidpi_calc (
    input  pidpi_pkg::t_cfg                          i_cfg,
    input  pidpi_pkg::t_state                        i_state,
    input  logic signed [pidpi_pkg::DATA_WIDTH-1:0]  i_setpoint,
    input  logic signed [pidpi_pkg::DATA_WIDTH-1:0]  i_measured,
    input  logic                                     i_clear,
    output pidpi_pkg::t_state                        o_state,
    output logic signed [pidpi_pkg::DATA_WIDTH-1:0]  o_drive
);

    localparam int DW    = pidpi_pkg::DATA_WIDTH;
    localparam int ERR_W = pidpi_pkg::ERR_W;
    localparam int SUM_W = pidpi_pkg::SUM_W;
    localparam int D1_W  = pidpi_pkg::D1_W;
    localparam int D2_W  = pidpi_pkg::D2_W;
    localparam int OPI_W = pidpi_pkg::OPI_W;
    localparam int GW    = pidpi_pkg::GAIN_W;
    localparam int ACC_W = pidpi_pkg::ACC_W;

    logic                     incr;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  e1;
    logic signed [ERR_W-1:0]  e2;
    logic signed [DW-1:0]     pd;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [SUM_W-1:0]  sum_bnd;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [D1_W-1:0]   d1;
    logic signed [D2_W-1:0]   d2;
    logic signed [D1_W-1:0]   op_p;
    logic signed [OPI_W-1:0]  op_i;
    logic signed [D2_W-1:0]   op_d;
    logic signed [GW+D1_W-1:0]  prod_p;
    logic signed [GW+OPI_W-1:0] prod_i;
    logic signed [GW+D2_W-1:0]  prod_d;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  pre;
    logic signed [ACC_W-1:0]  obnd;
    logic signed [ACC_W-1:0]  clamped;
    logic signed [ACC_W-1:0]  sat;

    assign incr = (i_cfg.mode == pidpi_pkg::MODE_INCREMENTAL);
    assign err  = ERR_W'(i_setpoint) - ERR_W'(i_measured);

    // Drop the incremental history when the clear flag is set.
    assign e1 = (incr && i_clear) ? '0 : i_state.prev_error;
    assign e2 = (incr && i_clear) ? '0 : i_state.prev_prev_error;
    assign pd = (incr && i_clear) ? '0 : i_state.prev_drive;

    // Integrate the error: saturate to the register range, then clamp if enabled.
    assign sum_raw = (SUM_W+1)'(i_state.error_sum) + (SUM_W+1)'(err);
    always_comb begin
        if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
            sum_sat = {sum_raw[SUM_W], {(SUM_W-1){~sum_raw[SUM_W]}}};
        end else begin
            sum_sat = sum_raw[SUM_W-1:0];
        end
    end

    assign sum_bnd = $signed({1'b0, i_cfg.int_bound});
    always_comb begin
        sum_new = sum_sat;
        if (i_cfg.int_clamp_on) begin
            if (sum_sat < -sum_bnd) begin
                sum_new = -sum_bnd;
            end else if (sum_sat > sum_bnd) begin
                sum_new = sum_bnd;
            end
        end
    end

    // Error differences; prev_error is raw in positional mode.
    assign d1 = D1_W'(err) - D1_W'(e1);
    assign d2 = D2_W'(err) - (D2_W'(e1) <<< 1) + D2_W'(e2);

    // Route the three multiplier operands by mode.
    assign op_p = incr ? d1 : D1_W'(err);
    assign op_i = incr ? OPI_W'(err) : OPI_W'(sum_new);
    assign op_d = incr ? d2 : D2_W'(d1);

    assign prod_p = i_cfg.gain_p * op_p;
    assign prod_i = i_cfg.gain_i * op_i;
    assign prod_d = i_cfg.gain_d * op_d;

    assign acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    assign shifted = acc >>> pidpi_pkg::FRAC_BITS;
    assign pre     = incr ? (shifted + ACC_W'(pd)) : shifted;

    // Clamp to the output bound if enabled, then saturate to the sample width.
    assign obnd = ACC_W'($signed({1'b0, i_cfg.out_bound}));
    always_comb begin
        clamped = pre;
        if (i_cfg.out_clamp_on) begin
            if (pre < -obnd) begin
                clamped = -obnd;
            end else if (pre > obnd) begin
                clamped = obnd;
            end
        end
        if (clamped < pidpi_pkg::DRV_MIN) begin
            sat = pidpi_pkg::DRV_MIN;
        end else if (clamped > pidpi_pkg::DRV_MAX) begin
            sat = pidpi_pkg::DRV_MAX;
        end else begin
            sat = clamped;
        end
    end

    assign o_drive = sat[DW-1:0];

    // Next controller state.
    always_comb begin
        o_state = i_state;
        o_state.prev_error = err;
        if (incr) begin
            o_state.prev_prev_error = e1;
            o_state.prev_drive      = sat[DW-1:0];
        end else begin
            o_state.error_sum = sum_new;
        end
    end

endmodule

[rtl/core/pid_position_incremental_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_*       in         tdata: setpoint, measured; tuser: clear_history
// m_*       out        tdata: drive
// cfg_*     in         write enable, register index, write data
//
// One sample pair is taken every cycle while m_tready is high; its drive
// value passes the input register, then the result register, to reach m_*.
// The error, integral update, three gain products and final clamp all lie
// between the two registers, as each beat needs the state the last left.
// Synchronous active-low reset clears the controller state and the handshake.
// A stalled result holds; the input register still fills behind it, and
// s_tready drops only when both registers are full and m_tready is low.
module pid_position_incremental_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [pidpi_pkg::S_TDATA_W-1:0]    i_s_tdata,   // setpoint, measured
    input  logic                               i_s_tuser,   // clear_history
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [pidpi_pkg::M_TDATA_W-1:0]    o_m_tdata,   // drive
    input  logic                               i_cfg_we,
    input  logic [pidpi_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [pidpi_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int DW = pidpi_pkg::DATA_WIDTH;

    pidpi_pkg::t_cfg   w_cfg;
    pidpi_pkg::t_state r_state;
    pidpi_pkg::t_state n_state;

    logic                 r_in_valid;
    logic signed [DW-1:0] r_setpoint;
    logic signed [DW-1:0] r_measured;
    logic                 r_clear;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_drive;
    logic signed [DW-1:0] n_drive;
    logic                 w_accept;
    logic                 w_advance;

    pidpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pidpi_calc u_calc (
        .i_cfg      (w_cfg),
        .i_state    (r_state),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .i_clear    (r_clear),
        .o_state    (n_state),
        .o_drive    (n_drive)
    );

    // Advance when the result register is free or being drained.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Handshake and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the input beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_setpoint <= $signed(i_s_tdata[DW-1:0]);
            r_measured <= $signed(i_s_tdata[2*DW-1:DW]);
            r_clear    <= i_s_tuser;
        end
    end

    // Hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_drive <= n_drive;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = pidpi_pkg::M_TDATA_W'($unsigned(r_drive));

endmodule

[rtl/core/pidpi_checker.sv]
`timescale 1ns / 1ps

`include "pid_position_incremental_core_macros.svh"

module pidpi_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_s_tready,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [pidpi_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    // Reset empties both registers: no result, input side open.
`PIDPI_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_m_tvalid && o_s_tready), "pidpi: not empty after reset")

    // Input side closes only behind a stalled result.
`PIDPI_ASSERT(a_ready_low_stall, i_clk, i_rst_n, !o_s_tready |-> (o_m_tvalid && !i_m_tready), "pidpi: ready low without output stall")

    // A stalled result stays offered.
`PIDPI_ASSERT(a_valid_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "pidpi: result dropped while stalled")

    // A stalled result keeps its value.
`PIDPI_ASSERT(a_data_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata), "pidpi: result changed while stalled")

endmodule

bind pid_position_incremental_core pidpi_checker u_pidpi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
